// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define CHK_ALWAYS(name, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("check failed");

// Antecedent implies consequent in the same cycle.
`define CHK_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// Antecedent implies consequent in the next cycle.
`define CHK_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ===== design/utf8d_pkg.sv =====
`timescale 1ns / 1ps
package utf8d_pkg;

  // One queued command: up to two UTF-16 units, then an optional status item.
  typedef struct packed {
    logic [1:0]  n_units;
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic        status;
    logic        bad;
  } cmd_t;

  localparam int FifoDepth = 4;
  localparam int FifoAw    = 2;

  localparam logic [20:0] SupplStart = 21'h10000;
  localparam logic [20:0] MaxPoint   = 21'h10FFFF;
  localparam logic [20:0] Min2Byte   = 21'h80;
  localparam logic [20:0] Min3Byte   = 21'h800;
  localparam logic [20:0] SurrFirst  = 21'hD800;
  localparam logic [20:0] SurrLast   = 21'hDFFF;
  localparam logic [15:0] HiSurrBase = 16'hD800;
  localparam logic [15:0] LoSurrBase = 16'hDC00;

endpackage

// ===== design/utf8_to_utf16_strict_decoder.sv =====
`timescale 1ns / 1ps
// Strict UTF-8 to UTF-16 decoder. Takes one byte per cycle and gives one
// UTF-16 unit per cycle when not stalled. A code point of U+10000 or above
// gives a surrogate pair, and the last byte of a string adds a status item
// (last = 1, bad = 1 if the string was malformed), so one byte can produce
// up to three results; lead bytes give no unit. The output side is a single
// register that issues one result per cycle while out_ready is high, fed
// from a four-entry command queue; input ready drops only while it is full.
module utf8_to_utf16_strict_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_code_unit,
  output logic        out_unit_valid,
  output logic        out_last,
  output logic        out_bad
);
  import utf8d_pkg::*;

  logic in_fire;
  logic push;
  logic full;
  logic pop;
  logic head_valid;
  cmd_t push_cmd;
  cmd_t head_cmd;

  assign in_ready = !full;
  assign in_fire  = in_valid && in_ready;

  utf8d_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .data_byte     (in_data_byte),
    .end_of_string (in_end_of_string),
    .push          (push),
    .cmd           (push_cmd)
  );

  utf8d_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  utf8d_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_cmd       (head_cmd),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_unit  (out_code_unit),
    .out_unit_valid (out_unit_valid),
    .out_last       (out_last),
    .out_bad        (out_bad)
  );

endmodule

// ===== design/utf8d_front.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module utf8d_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [7:0]        data_byte,
  input  logic              end_of_string,
  output logic              push,
  output utf8d_pkg::cmd_t   cmd
);
  import utf8d_pkg::*;

  logic [20:0] partial_r, partial_nxt;
  logic [1:0]  left_r, left_nxt;
  logic [1:0]  seq_r, seq_nxt;
  logic        failed_r, failed_nxt;

  logic        emit;
  logic        ok;
  logic        supp;
  logic        str_bad;
  logic [20:0] cp_emit;
  logic [20:0] cont_cp;
  logic [20:0] cp_off;

  assign cont_cp = {partial_r[14:0], data_byte[5:0]};

  always_comb begin
    partial_nxt = partial_r;
    left_nxt    = left_r;
    seq_nxt     = seq_r;
    failed_nxt  = failed_r;
    emit        = 1'b0;
    ok          = 1'b0;
    cp_emit     = {13'd0, data_byte};

    if (!failed_r) begin
      if (left_r == 2'd0) begin
        priority if (!data_byte[7]) begin
          emit = 1'b1;
        end else if (data_byte[7:5] == 3'b110) begin
          partial_nxt = {16'd0, data_byte[4:0]};
          left_nxt    = 2'd1;
          seq_nxt     = 2'd1;
        end else if (data_byte[7:4] == 4'b1110) begin
          partial_nxt = {17'd0, data_byte[3:0]};
          left_nxt    = 2'd2;
          seq_nxt     = 2'd2;
        end else if (data_byte[7:3] == 5'b11110) begin
          partial_nxt = {18'd0, data_byte[2:0]};
          left_nxt    = 2'd3;
          seq_nxt     = 2'd3;
        end else begin
          failed_nxt  = 1'b1;
          partial_nxt = '0;
          left_nxt    = 2'd0;
          seq_nxt     = 2'd0;
        end
      end else if (data_byte[7:6] != 2'b10) begin
        failed_nxt  = 1'b1;
        partial_nxt = '0;
        left_nxt    = 2'd0;
        seq_nxt     = 2'd0;
      end else begin
        partial_nxt = cont_cp;
        left_nxt    = left_r - 2'd1;
        if (left_r == 2'd1) begin
          unique case (seq_r)
            2'd1:    ok = cont_cp >= Min2Byte;
            2'd2:    ok = (cont_cp >= Min3Byte) &&
                          !((cont_cp >= SurrFirst) && (cont_cp <= SurrLast));
            default: ok = (cont_cp >= SupplStart) && (cont_cp <= MaxPoint);
          endcase
          if (ok) begin
            emit        = 1'b1;
            cp_emit     = cont_cp;
            partial_nxt = '0;
            seq_nxt     = 2'd0;
          end else begin
            failed_nxt  = 1'b1;
            partial_nxt = '0;
            seq_nxt     = 2'd0;
          end
        end
      end
    end

    // status must see a cut-off sequence before state clears
    str_bad = failed_nxt || (left_nxt != 2'd0);

    if (end_of_string) begin
      partial_nxt = '0;
      left_nxt    = 2'd0;
      seq_nxt     = 2'd0;
      failed_nxt  = 1'b0;
    end
  end

  assign supp        = cp_emit >= SupplStart;
  assign cp_off      = cp_emit - SupplStart;
  assign cmd.n_units = emit ? (supp ? 2'd2 : 2'd1) : 2'd0;
  assign cmd.unit0   = supp ? (HiSurrBase | {6'd0, cp_off[19:10]}) : cp_emit[15:0];
  assign cmd.unit1   = LoSurrBase | {6'd0, cp_off[9:0]};
  assign cmd.status  = end_of_string;
  assign cmd.bad     = str_bad;
  assign push        = in_fire && (emit || end_of_string);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      left_r    <= 2'd0;
      seq_r     <= 2'd0;
      failed_r  <= 1'b0;
    end else if (in_fire) begin
      partial_r <= partial_nxt;
      left_r    <= left_nxt;
      seq_r     <= seq_nxt;
      failed_r  <= failed_nxt;
    end
  end

  `CHK_IMPLY(a_fail_no_seq, failed_r, (left_r == 2'd0) && (seq_r == 2'd0))
  `CHK_IMPLY(a_left_in_seq, left_r != 2'd0, seq_r >= left_r)

endmodule

// ===== design/utf8d_fifo.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module utf8d_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  utf8d_pkg::cmd_t   push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output utf8d_pkg::cmd_t   head_cmd
);
  import utf8d_pkg::*;

  cmd_t              mem_r [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_r, rd_ptr_r;
  logic [FifoAw:0]   cnt_r;

  assign full       = cnt_r == (FifoAw + 1)'(FifoDepth);
  assign head_valid = cnt_r != '0;
  assign head_cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (FifoAw + 1)'(push) - (FifoAw + 1)'(pop);
    end
  end

  `CHK_IMPLY(a_no_overflow, push, !full || pop)
  `CHK_IMPLY(a_no_underflow, pop, head_valid)

endmodule

// ===== design/utf8d_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module utf8d_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  utf8d_pkg::cmd_t   head_cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_code_unit,
  output logic              out_unit_valid,
  output logic              out_last,
  output logic              out_bad
);
  import utf8d_pkg::*;

  logic [1:0]  step_r, step_nxt;
  logic        out_valid_r;
  logic [15:0] code_r;
  logic        uv_r, last_r, bad_r;

  logic [1:0]  total;
  logic        adv;
  logic        final_elem;
  logic        is_unit;
  logic [15:0] sel_code;

  assign total      = head_cmd.n_units + {1'b0, head_cmd.status};
  assign adv        = head_valid && (!out_valid_r || out_ready);
  assign final_elem = step_r == (total - 2'd1);
  assign is_unit    = step_r < head_cmd.n_units;
  assign sel_code   = !is_unit ? 16'd0 :
                      (step_r == 2'd0) ? head_cmd.unit0 : head_cmd.unit1;
  assign pop        = adv && final_elem;
  assign step_nxt   = !adv ? step_r : (final_elem ? 2'd0 : step_r + 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= 2'd0;
    end else begin
      step_r <= step_nxt;
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: load the next element of the head command
  always_ff @(posedge clk) begin
    if (adv) begin
      code_r <= sel_code;
      uv_r   <= is_unit;
      last_r <= !is_unit;
      bad_r  <= !is_unit && head_cmd.bad;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_unit  = code_r;
  assign out_unit_valid = uv_r;
  assign out_last       = last_r;
  assign out_bad        = bad_r;

  `CHK_IMPLY(a_step_idle, !head_valid, step_r == 2'd0)
  `CHK_IMPLY(a_step_bound, head_valid, step_r < total)

endmodule
